// ===== sv/srtk_pkg.sv =====
package srtk_pkg;
    localparam int MAX_KEEP_DEF = 8;
    localparam int COL_W = 31;
    localparam int MAG_W = 63;
    localparam int VAL_W = 64;
    localparam int LIM_W = 4;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic             cand;
        logic             last;
        logic [COL_W-1:0] col;
        logic [MAG_W-1:0] mag;
    } t_entry;

    typedef enum logic [0:0] {
        ST_INSERT = 1'b0,
        ST_EMIT   = 1'b1
    } t_state;
endpackage

// ===== sv/srtk_front.sv =====
module srtk_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [srtk_pkg::COL_W-1:0]  i_row_index,
    input  logic [srtk_pkg::COL_W-1:0]  i_column,
    input  logic [srtk_pkg::VAL_W-1:0]  i_value_bits,
    input  logic                        i_last_in_row,
    output logic                        o_q_valid,
    output srtk_pkg::t_entry            o_q_entry,
    input  logic                        i_q_pop
);
    import srtk_pkg::*;

    // two-entry queue, classification at the input
    t_entry r_q [QUEUE_DEPTH];
    logic   r_rd, r_wr;
    logic [1:0] r_cnt;
    t_entry w_new;
    logic   w_push, w_pop;

    always_comb begin
        w_new.col  = i_column;
        w_new.mag  = i_value_bits[MAG_W-1:0];
        w_new.last = i_last_in_row;
        w_new.cand = (i_column < i_row_index) && (i_value_bits[MAG_W-1:0] != '0);
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_pop     = i_q_pop && o_q_valid;
    assign o_q_entry = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= w_new;
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

// ===== sv/srtk_back.sv =====
module srtk_back #(
    parameter int MAX_KEEP = srtk_pkg::MAX_KEEP_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [srtk_pkg::LIM_W-1:0]  i_max_keep,
    input  logic                        i_q_valid,
    input  srtk_pkg::t_entry            i_q_entry,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [srtk_pkg::COL_W-1:0]  o_kept_column,
    output logic [srtk_pkg::MAG_W-1:0]  o_kept_magnitude,
    output logic                        o_entry_valid,
    output logic                        o_last_of_row
);
    import srtk_pkg::*;
    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

    logic [COL_W-1:0] r_col [MAX_KEEP];
    logic [MAG_W-1:0] r_mag [MAX_KEEP];
    logic [CW-1:0]    r_cnt, r_emit, r_n, n_cnt;
    t_state           r_state, n_state;
    logic [CW-1:0]    w_lim, w_eff;
    logic [MAX_KEEP-1:0] w_ge;
    logic             w_ins;
    logic [CW-1:0]    w_pos;
    logic             w_out_free;

    assign w_lim = (32'(i_max_keep) > MAX_KEEP) ? CW'(MAX_KEEP) : CW'(i_max_keep);
    assign w_eff = (r_cnt > w_lim) ? w_lim : r_cnt;

    // position = number of kept entries with magnitude >= new (sorted list)
    always_comb begin
        w_pos = '0;
        for (int k = 0; k < MAX_KEEP; k++) begin
            w_ge[k] = (CW'(k) < w_eff) && (r_mag[k] >= i_q_entry.mag);
            w_pos = w_pos + CW'(w_ge[k]);
        end
    end

    assign w_out_free = !o_valid || !i_stall;
    assign o_q_pop = (r_state == ST_INSERT) && i_q_valid;
    assign w_ins   = o_q_pop && i_q_entry.cand && (w_pos < w_lim);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_INSERT: if (o_q_pop) begin
                n_cnt = w_ins ? ((w_eff < w_lim) ? w_eff + 1'b1 : w_lim) : w_eff;
                if (i_q_entry.last) n_state = ST_EMIT;
            end
            ST_EMIT: if (w_out_free && (r_emit + 1'b1 >= r_n || r_n == '0)) begin
                n_state = ST_INSERT;
                n_cnt   = '0;
            end
            default: n_state = ST_INSERT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ins) begin
            for (int k = 0; k < MAX_KEEP; k++) begin
                if (CW'(k) == w_pos) begin
                    r_col[k] <= i_q_entry.col;
                    r_mag[k] <= i_q_entry.mag;
                end else if (CW'(k) > w_pos && k > 0) begin
                    r_col[k] <= r_col[(k > 0) ? k - 1 : 0];
                    r_mag[k] <= r_mag[(k > 0) ? k - 1 : 0];
                end
            end
        end
        if (r_state == ST_EMIT && w_out_free) begin
            o_entry_valid    <= (r_n != '0);
            o_last_of_row    <= (r_n == '0) || (r_emit + 1'b1 >= r_n);
            o_kept_column    <= (r_n == '0) ? '0 : r_col[r_emit[IW-1:0]];
            o_kept_magnitude <= (r_n == '0) ? '0 : r_mag[r_emit[IW-1:0]];
        end
        if (!i_rst_n) begin
            r_state <= ST_INSERT;
            r_cnt   <= '0;
            r_emit  <= '0;
            r_n     <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == ST_INSERT && n_state == ST_EMIT) begin
                r_emit <= '0;
                r_n    <= (n_cnt < w_lim) ? n_cnt : w_lim;
            end else if (r_state == ST_EMIT && w_out_free) begin
                r_emit <= r_emit + 1'b1;
            end
            if (r_state == ST_EMIT && w_out_free) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
        end
    end
endmodule

// ===== sv/sparse_row_top_k_magnitude_select.sv =====
// Channel | Direction | Signals
// input   | in        | i_valid / o_stall, i_row_index, i_column, i_value_bits, i_last_in_row
// output  | out       | o_valid / i_stall, o_kept_column, o_kept_magnitude, o_entry_valid,
//         |           | o_last_of_row
// config  | in        | i_cfg_we, i_cfg_wdata (max_keep)
//
// The insert stage sorts one entry per cycle into the kept list while no row is
// being emitted (one parallel compare row over MAX_KEEP slots).
// Row end: the kept results go out in order, or one empty result if none were kept;
// the sorter takes no entries then, the queue holds up to two.
// A two-entry queue sits between input classification and the sorter.
// Reset is synchronous, active low; kept list count and limit return to default.
// Output is registered; a stalled transfer holds its payload.
module sparse_row_top_k_magnitude_select #(
    parameter int MAX_KEEP = srtk_pkg::MAX_KEEP_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [srtk_pkg::LIM_W-1:0]  i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [srtk_pkg::COL_W-1:0]  i_row_index,
    input  logic [srtk_pkg::COL_W-1:0]  i_column,
    input  logic [srtk_pkg::VAL_W-1:0]  i_value_bits,
    input  logic                        i_last_in_row,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [srtk_pkg::COL_W-1:0]  o_kept_column,
    output logic [srtk_pkg::MAG_W-1:0]  o_kept_magnitude,
    output logic                        o_entry_valid,
    output logic                        o_last_of_row
);
    import srtk_pkg::*;

    logic [LIM_W-1:0] r_max_keep;
    logic   w_q_valid, w_q_pop;
    t_entry w_q_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max_keep <= LIM_W'(8);
        else if (i_cfg_we) r_max_keep <= i_cfg_wdata;
    end

    srtk_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_row_index, .i_column,
        .i_value_bits, .i_last_in_row,
        .o_q_valid(w_q_valid), .o_q_entry(w_q_entry), .i_q_pop(w_q_pop)
    );

    srtk_back #(.MAX_KEEP(MAX_KEEP)) u_back (
        .i_clk, .i_rst_n, .i_max_keep(r_max_keep),
        .i_q_valid(w_q_valid), .i_q_entry(w_q_entry), .o_q_pop(w_q_pop),
        .o_valid, .i_stall, .o_kept_column, .o_kept_magnitude,
        .o_entry_valid, .o_last_of_row
    );

    // an empty-row result is always the last of its row
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_entry_valid) |-> o_last_of_row) else $error("empty not last");
    // an empty-row result carries zero payload
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_entry_valid) |-> (o_kept_magnitude == '0))
        else $error("empty payload");
    // a kept magnitude is never zero
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_entry_valid) |-> (o_kept_magnitude != '0))
        else $error("zero kept");
endmodule

// ===== dv/srtk_checker.sv =====
`timescale 1ns / 1ps

module srtk_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [srtk_pkg::LIM_W-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [srtk_pkg::COL_W-1:0]  i_row_index,
    input  logic [srtk_pkg::COL_W-1:0]  i_column,
    input  logic [srtk_pkg::VAL_W-1:0]  i_value_bits,
    input  logic                        i_last_in_row,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [srtk_pkg::COL_W-1:0]  i_kept_column,
    input  logic [srtk_pkg::MAG_W-1:0]  i_kept_magnitude,
    input  logic                        i_entry_valid,
    input  logic                        i_last_of_row,
    output int                          o_fail_count,
    output int                          o_pending
);
    import srtk_pkg::*;

    localparam int KEEP_SLOTS = MAX_KEEP_DEF;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [MAG_W-1:0] mag;
        logic             entry_valid;
        logic             last;
    } t_kept_result;

    t_kept_result     row_results_q[$];
    logic [LIM_W-1:0] keep_limit_reg;
    logic [COL_W-1:0] top_cols[KEEP_SLOTS];
    logic [MAG_W-1:0] top_mags[KEEP_SLOTS];
    int               top_count;
    int               fails;

    assign o_fail_count = fails;
    assign o_pending    = row_results_q.size();

    function automatic int eff_limit();
        return (keep_limit_reg > KEEP_SLOTS) ? KEEP_SLOTS : int'(keep_limit_reg);
    endfunction

    // sorted insert, earlier arrival wins ties
    task automatic rank_entry(input logic [COL_W-1:0] col, input logic [MAG_W-1:0] mag,
                              input int lim);
        int pos;
        int n;
        pos = 0;
        if (top_count > lim) top_count = lim;
        while (pos < top_count && top_mags[pos] >= mag) pos++;
        if (pos < lim) begin
            n = (top_count < lim) ? top_count + 1 : lim;
            for (int k = n - 1; k > pos; k--) begin
                top_cols[k] = top_cols[k-1];
                top_mags[k] = top_mags[k-1];
            end
            top_cols[pos] = col;
            top_mags[pos] = mag;
            top_count = n;
        end
    endtask

    task automatic predict_entry();
        int               lim;
        int               n;
        logic [MAG_W-1:0] mag;
        t_kept_result     r;
        lim = eff_limit();
        mag = i_value_bits[MAG_W-1:0];
        if (i_column < i_row_index && mag != '0) rank_entry(i_column, mag, lim);
        if (i_last_in_row) begin
            n = (top_count < lim) ? top_count : lim;
            if (n == 0) begin
                r = '{col: '0, mag: '0, entry_valid: 1'b0, last: 1'b1};
                row_results_q.push_back(r);
            end
            for (int k = 0; k < n; k++) begin
                r = '{col: top_cols[k], mag: top_mags[k], entry_valid: 1'b1,
                      last: (k + 1 == n)};
                row_results_q.push_back(r);
            end
            top_count = 0;
        end
    endtask

    task automatic check_result();
        t_kept_result want;
        if (row_results_q.size() == 0) begin
            fails++;
            if (fails <= 10)
                $display("%0t: unexpected result col=%h mag=%h ev=%b last=%b", $realtime,
                         i_kept_column, i_kept_magnitude, i_entry_valid, i_last_of_row);
        end else begin
            want = row_results_q.pop_front();
            if (want.col !== i_kept_column || want.mag !== i_kept_magnitude ||
                want.entry_valid !== i_entry_valid || want.last !== i_last_of_row) begin
                fails++;
                if (fails <= 10)
                    $display("%0t: exp col=%h mag=%h ev=%b last=%b got col=%h mag=%h ev=%b last=%b",
                             $realtime, want.col, want.mag, want.entry_valid, want.last,
                             i_kept_column, i_kept_magnitude, i_entry_valid, i_last_of_row);
            end
        end
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            keep_limit_reg = LIM_W'(MAX_KEEP_DEF);
            top_count = 0;
            row_results_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_result();
            if (i_in_valid && !i_in_stall) predict_entry();
            if (i_cfg_we) keep_limit_reg = i_cfg_wdata;
        end
    end
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import srtk_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 24;   // covers the queue and the emit of a full kept list, with margin
    localparam int RANDOM_ITEMS   = 500;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [LIM_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_stall;
    logic [COL_W-1:0] row_index;
    logic [COL_W-1:0] column;
    logic [VAL_W-1:0] value_bits;
    logic             last_in_row;
    logic             out_valid;
    logic             out_stall;
    logic [COL_W-1:0] kept_column;
    logic [MAG_W-1:0] kept_magnitude;
    logic             entry_valid;
    logic             last_of_row;

    int fail_count;
    int pending;
    int items_sent;
    int quiet_cycles;
    int stall_left;
    bit no_idle;   // final stretch: no gaps on either side

    sparse_row_top_k_magnitude_select dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_valid          (in_valid),
        .o_stall          (in_stall),
        .i_row_index      (row_index),
        .i_column         (column),
        .i_value_bits     (value_bits),
        .i_last_in_row    (last_in_row),
        .o_valid          (out_valid),
        .i_stall          (out_stall),
        .o_kept_column    (kept_column),
        .o_kept_magnitude (kept_magnitude),
        .o_entry_valid    (entry_valid),
        .o_last_of_row    (last_of_row)
    );

    srtk_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_row_index      (row_index),
        .i_column         (column),
        .i_value_bits     (value_bits),
        .i_last_in_row    (last_in_row),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_kept_column    (kept_column),
        .i_kept_magnitude (kept_magnitude),
        .i_entry_valid    (entry_valid),
        .i_last_of_row    (last_of_row),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver back-pressure: random stall bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n || no_idle) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(1, 17) - 1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog: cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // One input transfer; valid stays high between back-to-back entries.
    task automatic send_entry(input logic [COL_W-1:0] row, input logic [COL_W-1:0] col,
                              input logic [VAL_W-1:0] val, input logic last);
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        row_index   <= row;
        column      <= col;
        value_bits  <= val;
        last_in_row <= last;
        do @(posedge i_clk); while (in_stall);
        items_sent++;
    endtask

    // Hold off until every expected row result is out and the pipe has drained.
    // It waits on the clock first so the checker has booked the last accepted entry.
    task automatic drain_all();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] lim);
        drain_all();
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Values: a mix of full-random bits and the special magnitudes.
    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        logic [MAG_W-1:0] tie_pool[4];
        tie_pool = '{63'h3FF0_0000_0000_0000, 63'h4000_0000_0000_0000,
                     63'h0000_0000_0000_0001, 63'h7FEF_FFFF_FFFF_FFFF};
        v = {$urandom, $urandom};
        case ($urandom_range(0, 11))
            0:       v = '0;                                  // plus zero
            1:       v = {1'b1, 63'h0};                       // minus zero
            2, 3, 4: v = {v[63], tie_pool[$urandom_range(0, 3)]};  // ties
            5:       v = {v[63], 63'h7FF0_0000_0000_0000};    // infinity
            6:       v = {v[63], 11'h7FF, 52'h8_0000_0000_0001}; // NaN pattern
            7:       v = {v[63], {MAG_W{1'b1}}};              // top magnitude
            default: ;
        endcase
        return v;
    endfunction

    // One row; mostly well-formed lower-triangular candidates, some noise.
    task automatic send_row(input int len);
        logic [COL_W-1:0] row;
        logic [COL_W-1:0] col;
        row = ($urandom_range(0, 3) == 0) ? COL_W'($urandom_range(1, 40))
                                          : COL_W'($urandom);
        if (row == '0) row = 1;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 15) == 0) row = COL_W'($urandom);  // row tag drift
            if ($urandom_range(0, 4) != 0 && row != '0)
                col = COL_W'($urandom_range(0, int'(row) - 1));
            else
                col = COL_W'($urandom_range(int'(row), 32'h7FFF_FFFF));
            send_entry(row, col, pick_value(), k == len - 1);
        end
    endtask

    task automatic random_phase(input int items);
        int target;
        target = items_sent + items;
        while (items_sent < target)
            send_row(($urandom_range(0, 9) == 0) ? $urandom_range(9, 14)
                                                 : $urandom_range(1, 8));
    endtask

    initial begin
        no_idle     = 1'b0;
        items_sent  = 0;
        i_rst_n     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        row_index   = '0;
        column      = '0;
        value_bits  = '0;
        last_in_row = 1'b0;
        out_stall   = 1'b0;
        stall_left  = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed row at the reset limit of 8: zero, minus zero, diagonal,
        // upper entry, extreme columns, ties, infinity, NaN, overflow past 8.
        send_entry(31'h7FFF_FFFF, 31'h0,         '0,                         1'b0);
        send_entry(31'h7FFF_FFFF, 31'h1,         {1'b1, 63'h0},              1'b0);
        send_entry(31'd100,       31'd100,       64'h3FF0_0000_0000_0000,    1'b0);
        send_entry(31'd100,       31'h7FFF_FFFF, 64'h4000_0000_0000_0000,    1'b0);
        send_entry(31'h7FFF_FFFF, 31'h7FFF_FFFE, 64'hBFF0_0000_0000_0000,    1'b0);
        send_entry(31'h7FFF_FFFF, 31'h0,         64'h3FF0_0000_0000_0000,    1'b0);
        send_entry(31'h7FFF_FFFF, 31'h5555_5555, 64'h7FF0_0000_0000_0000,    1'b0);
        send_entry(31'h7FFF_FFFF, 31'h2AAA_AAAA, 64'hFFF8_0000_0000_0001,    1'b0);
        send_entry(31'h7FFF_FFFF, 31'd7,         64'hFFFF_FFFF_FFFF_FFFF,    1'b0);
        send_entry(31'h7FFF_FFFF, 31'd8,         64'h0000_0000_0000_0001,    1'b0);
        send_entry(31'h7FFF_FFFF, 31'd9,         64'h8000_0000_0000_0002,    1'b0);
        send_entry(31'h7FFF_FFFF, 31'd10,        64'h5555_5555_5555_5555,    1'b0);
        send_entry(31'h7FFF_FFFF, 31'd11,        64'hAAAA_AAAA_AAAA_AAAA,    1'b0);
        send_entry(31'h7FFF_FFFF, 31'd12,        64'h0000_0000_0000_0001,    1'b0);
        // last entry is not a candidate, list still emitted
        send_entry(31'd5,         31'd5,         64'h4010_0000_0000_0000,    1'b1);
        // empty row: only a non-candidate, gives the invalid result
        send_entry(31'd0,         31'd0,         64'h3FF0_0000_0000_0000,    1'b1);
        // single-entry row
        send_entry(31'd1,         31'd0,         64'h8000_0000_0000_0001,    1'b1);

        // Limit sweep: keep one, keep none, saturated, full, then random.
        write_limit(LIM_W'(1));
        random_phase(60);
        write_limit(LIM_W'(0));
        random_phase(30);
        write_limit(LIM_W'(15));
        random_phase(60);
        write_limit(LIM_W'(8));
        random_phase(80);
        write_limit(LIM_W'($urandom_range(1, 7)));
        random_phase(90);
        write_limit(LIM_W'($urandom_range(2, 6)));
        random_phase(90);

        // final stretch with no idling on either side
        write_limit(LIM_W'($urandom_range(3, 8)));
        no_idle = 1'b1;
        random_phase(RANDOM_ITEMS - items_sent + 20);

        drain_all();
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
